// ===== rtl/aoc_pkg.sv =====
package aoc_pkg;

  localparam int SIDE_W     = 14;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 14;
  localparam int CELL_SIZE_DEF = 8;

  localparam logic [SIDE_W-1:0] WIDTH_RST  = SIDE_W'(256);
  localparam logic [SIDE_W-1:0] HEIGHT_RST = SIDE_W'(256);
  localparam logic [PIX_W-1:0]  LIGHT_RST  = PIX_W'(224);
  localparam logic [PIX_W-1:0]  DARK_RST   = PIX_W'(192);
  localparam logic [PIX_W-1:0]  ALPHA_MAX  = PIX_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = CFG_IDX_W'(0),
    REG_HEIGHT = CFG_IDX_W'(1),
    REG_LIGHT  = CFG_IDX_W'(2),
    REG_DARK   = CFG_IDX_W'(3)
  } cfg_idx_t;

  typedef struct packed {
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic [PIX_W-1:0]  light;
    logic [PIX_W-1:0]  dark;
  } cfg_t;

  // position and background of one pixel, worked out when it is taken in
  typedef struct packed {
    logic [SIDE_W-1:0] col;
    logic [SIDE_W-1:0] row;
    logic              row_end;
    logic              frame_end;
    logic [PIX_W-1:0]  bg;
  } pos_t;

endpackage

// ===== rtl/aoc_raster.sv =====
module aoc_raster #(
  parameter int CELL_SIZE = aoc_pkg::CELL_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  aoc_pkg::cfg_t cfg,
  input  logic          step,
  output aoc_pkg::pos_t pos
);

  localparam int SUB_W = $clog2(CELL_SIZE);
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(CELL_SIZE - 1);

  logic [aoc_pkg::SIDE_W-1:0] col_r, row_r;
  logic [SUB_W-1:0]           col_sub_r, row_sub_r;
  logic                       col_par_r, row_par_r;

  logic [aoc_pkg::SIDE_W-1:0] w_m1, h_m1;
  logic                       rend, fend;

  // zero size counts as one
  assign w_m1 = (cfg.width  == '0) ? '0 : cfg.width  - aoc_pkg::SIDE_W'(1);
  assign h_m1 = (cfg.height == '0) ? '0 : cfg.height - aoc_pkg::SIDE_W'(1);

  assign rend = (col_r >= w_m1);
  assign fend = rend && (row_r >= h_m1);

  always_comb begin
    pos.col       = col_r;
    pos.row       = (row_r > h_m1) ? '0 : h_m1 - row_r;
    pos.row_end   = rend;
    pos.frame_end = fend;
    pos.bg        = (col_par_r ^ row_par_r) ? cfg.dark : cfg.light;
  end

  // sub-cell counters carry the parity of col/CELL_SIZE and row/CELL_SIZE
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      col_sub_r <= '0;
      row_sub_r <= '0;
      col_par_r <= 1'b0;
      row_par_r <= 1'b0;
    end else if (step) begin
      if (rend) begin
        col_r     <= '0;
        col_sub_r <= '0;
        col_par_r <= 1'b0;
        if (fend) begin
          row_r     <= '0;
          row_sub_r <= '0;
          row_par_r <= 1'b0;
        end else begin
          row_r <= row_r + aoc_pkg::SIDE_W'(1);
          if (row_sub_r == SUB_LAST) begin
            row_sub_r <= '0;
            row_par_r <= ~row_par_r;
          end else begin
            row_sub_r <= row_sub_r + SUB_W'(1);
          end
        end
      end else begin
        col_r <= col_r + aoc_pkg::SIDE_W'(1);
        if (col_sub_r == SUB_LAST) begin
          col_sub_r <= '0;
          col_par_r <= ~col_par_r;
        end else begin
          col_sub_r <= col_sub_r + SUB_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/aoc_blend.sv =====
module aoc_blend (
  input  logic [aoc_pkg::PIX_W-1:0] chan,
  input  logic [aoc_pkg::PIX_W-1:0] alpha,
  input  logic [aoc_pkg::PIX_W-1:0] bg,
  output logic [aoc_pkg::PIX_W-1:0] res
);

  logic [aoc_pkg::PIX_W-1:0]   inv;
  logic [2*aoc_pkg::PIX_W-1:0] p_src, p_bg;
  logic [2*aoc_pkg::PIX_W:0]   t, rnd;

  assign inv   = aoc_pkg::ALPHA_MAX - alpha;
  assign p_src = {{aoc_pkg::PIX_W{1'b0}}, chan} * {{aoc_pkg::PIX_W{1'b0}}, alpha};
  assign p_bg  = {{aoc_pkg::PIX_W{1'b0}}, bg} * {{aoc_pkg::PIX_W{1'b0}}, inv};
  assign t     = {1'b0, p_src} + {1'b0, p_bg};
  // divide by 255, rounding down: (t + 1 + t/256) / 256
  assign rnd   = t + (2*aoc_pkg::PIX_W+1)'(1) + (t >> aoc_pkg::PIX_W);

  always_comb begin
    priority if (alpha == aoc_pkg::ALPHA_MAX) begin
      res = chan;
    end else if (alpha == '0) begin
      res = bg;
    end else begin
      res = rnd[2*aoc_pkg::PIX_W-1:aoc_pkg::PIX_W];
    end
  end

endmodule

// ===== rtl/alpha_over_checkerboard.sv =====
// An accepted input item passes the input register, then the result register.
// Throughput: one item per clock unless out_stall holds it; the input and result
// registers form a two-entry pipe, so a new item is taken while a result waits.
// The blend stage (two 8x8 products and an add per channel) sets the clock.
// Reset (rst_n, synchronous, low): pipe emptied, counters to zero, config
// registers to width 256, height 256, light 224, dark 192.
module alpha_over_checkerboard #(
  parameter int CELL_SIZE = aoc_pkg::CELL_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [aoc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aoc_pkg::CFG_DATA_W-1:0] cfg_data,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [aoc_pkg::PIX_W-1:0]      in_blue,
  input  logic [aoc_pkg::PIX_W-1:0]      in_green,
  input  logic [aoc_pkg::PIX_W-1:0]      in_red,
  input  logic [aoc_pkg::PIX_W-1:0]      in_alpha,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [aoc_pkg::PIX_W-1:0]      out_blue,
  output logic [aoc_pkg::PIX_W-1:0]      out_green,
  output logic [aoc_pkg::PIX_W-1:0]      out_red,
  output logic [aoc_pkg::SIDE_W-1:0]     out_col,
  output logic [aoc_pkg::SIDE_W-1:0]     out_row,
  output logic                           row_end,
  output logic                           frame_end
);

  // ---------------------------------------------------------------------
  // Configuration registers. Always ready; unknown indexes are dropped.
  // ---------------------------------------------------------------------
  aoc_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= aoc_pkg::WIDTH_RST;
      cfg_r.height <= aoc_pkg::HEIGHT_RST;
      cfg_r.light  <= aoc_pkg::LIGHT_RST;
      cfg_r.dark   <= aoc_pkg::DARK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aoc_pkg::REG_WIDTH:  cfg_r.width  <= cfg_data[aoc_pkg::SIDE_W-1:0];
        aoc_pkg::REG_HEIGHT: cfg_r.height <= cfg_data[aoc_pkg::SIDE_W-1:0];
        aoc_pkg::REG_LIGHT:  cfg_r.light  <= cfg_data[aoc_pkg::PIX_W-1:0];
        aoc_pkg::REG_DARK:   cfg_r.dark   <= cfg_data[aoc_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipe control. Stage 1 is the input register, stage 2 the result
  // register. Stall only when both hold an item and the sink is stalling.
  // ---------------------------------------------------------------------
  logic s1_valid_r, out_valid_r;
  logic in_take, s2_load;

  assign s2_load  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s2_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_load) begin
        out_valid_r <= s1_valid_r;
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Raster position: counters advance once per accepted item, and the
  // item's position, flags and checkerboard shade are captured with it.
  // ---------------------------------------------------------------------
  aoc_pkg::pos_t pos_now;

  aoc_raster #(
    .CELL_SIZE (CELL_SIZE)
  ) u_raster (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .step  (in_take),
    .pos   (pos_now)
  );

  // stage 1 payload
  logic [aoc_pkg::PIX_W-1:0] s1_blue_r, s1_green_r, s1_red_r, s1_alpha_r;
  aoc_pkg::pos_t             s1_pos_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_blue_r  <= in_blue;
      s1_green_r <= in_green;
      s1_red_r   <= in_red;
      s1_alpha_r <= in_alpha;
      s1_pos_r   <= pos_now;
    end
  end

  // ---------------------------------------------------------------------
  // Blend, one unit per channel, into the result register.
  // ---------------------------------------------------------------------
  logic [aoc_pkg::PIX_W-1:0] blue_nxt, green_nxt, red_nxt;

  aoc_blend u_blend_b (
    .chan (s1_blue_r), .alpha (s1_alpha_r), .bg (s1_pos_r.bg), .res (blue_nxt)
  );
  aoc_blend u_blend_g (
    .chan (s1_green_r), .alpha (s1_alpha_r), .bg (s1_pos_r.bg), .res (green_nxt)
  );
  aoc_blend u_blend_r (
    .chan (s1_red_r), .alpha (s1_alpha_r), .bg (s1_pos_r.bg), .res (red_nxt)
  );

  logic [aoc_pkg::PIX_W-1:0]  out_blue_r, out_green_r, out_red_r;
  logic [aoc_pkg::SIDE_W-1:0] out_col_r, out_row_r;
  logic                       row_end_r, frame_end_r;

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      out_blue_r  <= blue_nxt;
      out_green_r <= green_nxt;
      out_red_r   <= red_nxt;
      out_col_r   <= s1_pos_r.col;
      out_row_r   <= s1_pos_r.row;
      row_end_r   <= s1_pos_r.row_end;
      frame_end_r <= s1_pos_r.frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_blue  = out_blue_r;
  assign out_green = out_green_r;
  assign out_red   = out_red_r;
  assign out_col   = out_col_r;
  assign out_row   = out_row_r;
  assign row_end   = row_end_r;
  assign frame_end = frame_end_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // the last pixel of a frame is always the last of its row
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!frame_end_r || row_end_r))
    else $error("frame_end without row_end");

  // frame end lands on the top destination row after the flip
  a_frame_row0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_end_r) |-> (out_row_r == '0))
    else $error("frame_end on non-zero flipped row");

  // an item held in stage 1 during a stall is not lost
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_load) |=> (s1_valid_r && out_valid_r))
    else $error("stage 1 item dropped while stalled");

endmodule
